// ===== hdl/sndw_pkg.sv =====
`timescale 1ns / 1ps

package sndw_pkg;

  // Input item geometry
  localparam int unsigned MAG_W       = 32;
  localparam int unsigned BCD_CELLS   = 10;  // decimal digits of 2^31
  localparam int unsigned MAX_DIGITS  = 8;
  localparam int unsigned S_TDATA_W   = 48;
  localparam int unsigned M_TDATA_W   = 16;

  // Command codes (tuser)
  localparam logic [1:0] CMD_NUMBER = 2'd0;
  localparam logic [1:0] CMD_DIGIT  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Code-B data values
  localparam logic [7:0] CODE_BLANK = 8'h0F;
  localparam logic [7:0] CODE_MINUS = 8'h0A;
  localparam logic [7:0] CODE_DP    = 8'h80;
  localparam logic [3:0] ADDR_BASE  = 4'h1;
  localparam logic [7:0] DIGIT_MAX  = 8'd9;

  // Config registers
  localparam logic       REG_DIGIT_COUNT   = 1'b0;
  localparam logic [3:0] DIGIT_COUNT_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Control for the BCD cell row
  typedef struct packed {
    logic clear;      // zero every digit
    logic dabble;     // add-3 correct and shift one bit in from below
    logic shift_out;  // move every digit one cell toward cell 0
  } chain_ctrl_t;

endpackage

// ===== hdl/sndw_bcd_cell.sv =====
`timescale 1ns / 1ps

module sndw_bcd_cell (
  input  logic                  clk,
  input  sndw_pkg::chain_ctrl_t ctrl,
  input  logic                  cin,
  input  logic [3:0]            upper_digit,
  output logic                  cout,
  output logic [3:0]            digit
);

  logic [3:0] adj;

  // Add 3 when the digit would overflow after doubling
  assign adj  = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign cout = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.dabble) begin
      digit <= {adj[2:0], cin};
    end else if (ctrl.shift_out) begin
      digit <= upper_digit;
    end
  end

endmodule

// ===== hdl/sndw_bcd_chain.sv =====
`timescale 1ns / 1ps

module sndw_bcd_chain (
  input  logic                                   clk,
  input  sndw_pkg::chain_ctrl_t                  ctrl,
  input  logic                                   serial_in,
  output logic [sndw_pkg::BCD_CELLS-1:0][3:0]    digits
);

  localparam int unsigned N = sndw_pkg::BCD_CELLS;

  logic [N:0]          carry;
  logic [N:0][3:0]     upper;

  assign carry[0] = serial_in;
  assign upper[N] = 4'd0;

  // Cell 0 holds the ones digit; carries ripple upward, digits drain downward
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign upper[i] = digits[i];
    sndw_bcd_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cin         (carry[i]),
      .upper_digit (upper[i+1]),
      .cout        (carry[i+1]),
      .digit       (digits[i])
    );
  end

endmodule

// ===== hdl/signed_number_digit_register_writer_unit.sv =====
`timescale 1ns / 1ps
// Show-number shifts the magnitude through the BCD cell row, scans for the digit count,
//   then issues its writes from a register, one write per cycle while the output is not stalled.
// Show-digit and clear go straight to writing; a show-digit out of range writes nothing.
// One item at a time; the next item is taken only once the last write of the current one
//   has been issued. Output stalls hold the writer.
// Reset (rst, synchronous): idle, output empty, digit_count back to 8.
module signed_number_digit_register_writer_unit #(
  parameter int unsigned MAX_DIGITS = sndw_pkg::MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] number, [34:32] position, [42:35] digit_value, [43] decimal_point
  input  logic [sndw_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] command
  input  logic [1:0]  s_tuser,
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] register_address, [11:4] data_byte
  output logic [sndw_pkg::M_TDATA_W-1:0] m_tdata,
  output logic        m_tlast,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N = sndw_pkg::BCD_CELLS;
  localparam logic [3:0] LIM_MAX = 4'(MAX_DIGITS);

  // Config register
  logic [3:0] digit_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == sndw_pkg::REG_DIGIT_COUNT);
  assign prdata = (paddr[2] == sndw_pkg::REG_DIGIT_COUNT) ? {28'd0, digit_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= sndw_pkg::DIGIT_COUNT_RESET;
    end else if (cfg_wr) begin
      digit_count <= pwdata[3:0];
    end
  end

  // Positions in use
  logic [3:0] lim_now;
  assign lim_now = (digit_count == 4'd0)  ? 4'd1 :
                   (digit_count > LIM_MAX) ? LIM_MAX : digit_count;

  // Input fields
  logic [31:0] in_number;
  logic [2:0]  in_position;
  logic [7:0]  in_digit_value;
  logic        in_decimal_point;
  assign in_number        = s_tdata[31:0];
  assign in_position      = s_tdata[34:32];
  assign in_digit_value   = s_tdata[42:35];
  assign in_decimal_point = s_tdata[43];

  // Control and payload registers
  sndw_pkg::state_t state, state_next;
  logic [4:0]  cnt, cnt_next;
  logic [31:0] mag, mag_next;
  logic [1:0]  cmd, cmd_next;
  logic [7:0]  data1, data1_next;
  logic        neg, neg_next;
  logic [3:0]  ndig, ndig_next;
  logic [3:0]  p, p_next;
  logic [3:0]  lim, lim_next;
  logic        m_tvalid_next;
  logic [sndw_pkg::M_TDATA_W-1:0] m_tdata_next;
  logic        m_tlast_next;

  sndw_pkg::chain_ctrl_t   chain_ctrl;
  logic [N-1:0][3:0]       digits;

  sndw_bcd_chain u_chain (
    .clk       (clk),
    .ctrl      (chain_ctrl),
    .serial_in (mag[31]),
    .digits    (digits)
  );

  // Significant digit count, zero counts as one digit
  logic [3:0] ndig_scan;
  always_comb begin
    ndig_scan = 4'd1;
    for (int i = 0; i < N; i++) begin
      if (digits[i] != 4'd0) ndig_scan = 4'(i + 1);
    end
  end

  // Data for the current write
  logic [7:0] cur_data;
  logic       cur_last;
  logic       out_free;
  always_comb begin
    case (cmd)
      sndw_pkg::CMD_NUMBER: begin
        if (p < ndig)                 cur_data = {4'd0, digits[0]};
        else if (neg && (p == ndig))  cur_data = sndw_pkg::CODE_MINUS;
        else                          cur_data = sndw_pkg::CODE_BLANK;
      end
      sndw_pkg::CMD_DIGIT: cur_data = data1;
      default:             cur_data = sndw_pkg::CODE_BLANK;
    endcase
    cur_last = (cmd == sndw_pkg::CMD_DIGIT) || (p == lim - 4'd1);
  end
  assign out_free = !m_tvalid || m_tready;

  // Next state and outputs
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    mag_next      = mag;
    cmd_next      = cmd;
    data1_next    = data1;
    neg_next      = neg;
    ndig_next     = ndig;
    p_next        = p;
    lim_next      = lim;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tlast_next  = m_tlast;
    chain_ctrl    = '0;
    s_tready      = 1'b0;

    case (state)
      sndw_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd_next = s_tuser;
          lim_next = lim_now;
          neg_next = in_number[31];
          mag_next = in_number[31] ? 32'd0 - in_number : in_number;
          cnt_next = 5'd0;
          data1_next = ((in_digit_value <= sndw_pkg::DIGIT_MAX) ?
                        in_digit_value : sndw_pkg::CODE_BLANK) |
                       (in_decimal_point ? sndw_pkg::CODE_DP : 8'd0);
          case (s_tuser)
            sndw_pkg::CMD_NUMBER: begin
              chain_ctrl.clear = 1'b1;
              state_next = sndw_pkg::ST_CONV;
            end
            sndw_pkg::CMD_DIGIT: begin
              p_next = {1'b0, in_position};
              if ({1'b0, in_position} < lim_now) state_next = sndw_pkg::ST_EMIT;
            end
            sndw_pkg::CMD_CLEAR: begin
              p_next = 4'd0;
              state_next = sndw_pkg::ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      sndw_pkg::ST_CONV: begin
        chain_ctrl.dabble = 1'b1;
        mag_next = {mag[30:0], 1'b0};
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) state_next = sndw_pkg::ST_SCAN;
      end
      sndw_pkg::ST_SCAN: begin
        ndig_next  = ndig_scan;
        p_next     = 4'd0;
        state_next = sndw_pkg::ST_EMIT;
      end
      sndw_pkg::ST_EMIT: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {4'd0, cur_data, p + sndw_pkg::ADDR_BASE};
          m_tlast_next  = cur_last;
          chain_ctrl.shift_out = 1'b1;
          p_next = p + 4'd1;
          if (cur_last) state_next = sndw_pkg::ST_IDLE;
        end
      end
      default: state_next = sndw_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sndw_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    mag     <= mag_next;
    cmd     <= cmd_next;
    data1   <= data1_next;
    neg     <= neg_next;
    ndig    <= ndig_next;
    p       <= p_next;
    lim     <= lim_next;
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
  end

endmodule

// ===== sim/digit_write_checker.sv =====
`timescale 1ns / 1ps

module digit_write_checker (
  input  logic                           clk,
  input  logic                           rst,
  // Command side
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [sndw_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]                     s_tuser,
  // Digit write side
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [sndw_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           m_tlast,
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  // Status to the testbench top
  output int                             fail_count,
  output int                             pending,
  output int                             writes_checked
);

  localparam logic [2:0] DIGIT_COUNT_ADDR = 3'(sndw_pkg::REG_DIGIT_COUNT) << 2;
  localparam int         REPORT_LIMIT     = 50;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } digit_write_t;

  digit_write_t expected_writes[$];
  digit_write_t head;
  logic [3:0]   digit_count_reg;

  // One line per mismatch, quiet after the first few dozen
  task automatic report_mismatch(input string msg);
    if (fail_count < REPORT_LIMIT) begin
      $display("[%0t] digit write %0d: %s", $time, writes_checked, msg);
    end
    fail_count++;
  endtask

  // Expected register writes for one command item
  function automatic void predict_writes(input logic [1:0] cmd, input logic [31:0] number,
                                         input logic [2:0] pos, input logic [7:0] val,
                                         input logic dp);
    logic [7:0]  codes [sndw_pkg::MAX_DIGITS];
    int unsigned span;
    int unsigned p;
    int unsigned n;
    int unsigned first_pos;
    logic [31:0] mag;
    logic        neg;
    digit_write_t w;

    // digit count is clamped to 1..MAX_DIGITS
    span = (digit_count_reg == 0) ? 1 :
           (digit_count_reg > sndw_pkg::MAX_DIGITS) ? sndw_pkg::MAX_DIGITS :
           int'(digit_count_reg);
    n = 0;
    first_pos = 0;
    case (cmd)
      sndw_pkg::CMD_NUMBER: begin
        neg = number[31];
        mag = neg ? -number : number;
        p = 0;
        if (mag == 0) begin
          codes[0] = 8'd0;
          p = 1;
        end else begin
          // digits beyond the span are dropped
          while (mag != 0 && p < span) begin
            codes[p] = 8'(mag % 10);
            mag = mag / 10;
            p++;
          end
        end
        if (neg && p < span) begin
          codes[p] = sndw_pkg::CODE_MINUS;
          p++;
        end
        while (p < span) begin
          codes[p] = sndw_pkg::CODE_BLANK;
          p++;
        end
        n = span;
      end
      sndw_pkg::CMD_DIGIT: begin
        if (pos < span) begin
          codes[0] = (val <= sndw_pkg::DIGIT_MAX) ? val : sndw_pkg::CODE_BLANK;
          if (dp) codes[0] = codes[0] | sndw_pkg::CODE_DP;
          first_pos = pos;
          n = 1;
        end
      end
      sndw_pkg::CMD_CLEAR: begin
        for (p = 0; p < span; p++) codes[p] = sndw_pkg::CODE_BLANK;
        n = span;
      end
      default: ;
    endcase

    for (p = 0; p < n; p++) begin
      w.addr = sndw_pkg::ADDR_BASE + 4'(first_pos + p);
      w.data = codes[p];
      w.last = (p == n - 1);
      expected_writes.push_back(w);
    end
  endfunction

  // Monitor all three ports at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      expected_writes.delete();
      digit_count_reg = sndw_pkg::DIGIT_COUNT_RESET;
      fail_count = 0;
      writes_checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write addr 0x%0h data 0x%0h",
                                    m_tdata[3:0], m_tdata[11:4]));
        end else begin
          head = expected_writes.pop_front();
          if (m_tdata[3:0] != head.addr)
            report_mismatch($sformatf("address 0x%0h, expected 0x%0h",
                                      m_tdata[3:0], head.addr));
          if (m_tdata[11:4] != head.data)
            report_mismatch($sformatf("data 0x%0h, expected 0x%0h",
                                      m_tdata[11:4], head.data));
          if (m_tlast != head.last)
            report_mismatch($sformatf("last %0b, expected %0b", m_tlast, head.last));
        end
        writes_checked++;
      end
      if (s_tvalid && s_tready)
        predict_writes(s_tuser, s_tdata[31:0], s_tdata[34:32], s_tdata[42:35], s_tdata[43]);
      if (psel && penable && pwrite && pready && paddr == DIGIT_COUNT_ADDR)
        digit_count_reg = pwdata[3:0];
    end
    pending = expected_writes.size();
  end

endmodule

// ===== sim/signed_number_digit_register_writer_unit_test.sv =====
`timescale 1ns / 1ps

module signed_number_digit_register_writer_unit_test;

  localparam logic [1:0] CMD_UNUSED       = 2'd3;
  localparam logic [2:0] DIGIT_COUNT_ADDR = 3'(sndw_pkg::REG_DIGIT_COUNT) << 2;
  localparam int         SETTLE_CYCLES    = 64;
  localparam int         WATCHDOG_LIMIT   = 4000;
  localparam logic [31:0] NUMBER_EDGES [5] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                               32'h7FFF_FFFF, 32'h8000_0000};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  // [31:0] number, [34:32] position, [42:35] digit_value, [43] decimal_point
  logic [sndw_pkg::S_TDATA_W-1:0] s_tdata;
  // [1:0] command
  logic [1:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  // [3:0] register_address, [11:4] data_byte
  logic [sndw_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tlast;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [2:0]                     paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  int    fail_count;
  int    pending;
  int    writes_checked;
  int    snd_idle_pct;
  int    rcv_stall_pct;
  int    number_items;
  int    digit_items;
  int    clear_items;
  int    unused_items;
  string counts_written;

  signed_number_digit_register_writer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  digit_write_checker chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .writes_checked (writes_checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side backpressure
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("signed_number_digit_register_writer_unit_test NOT OK");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    snd_idle_pct  = (mode == IDLE_SENDER)   ? 58 : (mode == IDLE_BOTH) ? 30 : 0;
    rcv_stall_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 30 : 0;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] number,
                           input logic [2:0] pos, input logic [7:0] val, input logic dp);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= sndw_pkg::S_TDATA_W'({dp, val, pos, number});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    case (cmd)
      sndw_pkg::CMD_NUMBER: number_items++;
      sndw_pkg::CMD_DIGIT:  digit_items++;
      sndw_pkg::CMD_CLEAR:  clear_items++;
      default:              unused_items++;
    endcase
  endtask

  // Stop sending and wait for every outstanding digit write
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Register write once the block has gone quiet
  task automatic set_digit_count(input logic [3:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIGIT_COUNT_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    counts_written = {counts_written, $sformatf(" %0d", value)};
  endtask

  // Random commands; unused codes ride along but are not counted
  task automatic run_phase(input logic [3:0] count_value, input idle_mode_t mode,
                           input int n_items);
    int          done;
    bit          paused;
    int unsigned r;
    int unsigned k;
    longint unsigned lim;
    logic [1:0]  cmd;
    logic [31:0] number;

    set_digit_count(count_value);
    set_idling(mode);
    done = 0;
    paused = 1'b0;
    while (done < n_items) begin
      // hold off mid-phase until every write is out
      if (!paused && done == n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      cmd = (r < 55) ? sndw_pkg::CMD_NUMBER : (r < 80) ? sndw_pkg::CMD_DIGIT :
            (r < 93) ? sndw_pkg::CMD_CLEAR : CMD_UNUSED;
      number = $urandom;
      if (cmd == sndw_pkg::CMD_NUMBER) begin
        case ($urandom_range(9))
          0, 1, 2, 3: number = $urandom;
          4, 5, 6, 7: begin
            // magnitude of a random number of decimal digits
            k = $urandom_range(1, 9);
            lim = 1;
            repeat (k) lim *= 10;
            number = 32'($urandom % lim);
            if ($urandom_range(1)) number = -number;
          end
          8: number = NUMBER_EDGES[$urandom_range(4)];
          default: begin
            // decade boundaries: 10^k-1 and 10^(k-1)
            k = $urandom_range(1, 9);
            lim = 1;
            repeat (k - 1) lim *= 10;
            number = $urandom_range(1) ? 32'(lim * 10 - 1) : 32'(lim);
            if ($urandom_range(1)) number = -number;
          end
        endcase
      end
      send_item(cmd, number, 3'($urandom), $urandom_range(1) ? 8'($urandom_range(9)) :
                8'($urandom), 1'($urandom));
      if (cmd != CMD_UNUSED) done++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= sndw_pkg::CMD_NUMBER;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    number_items = 0;
    digit_items = 0;
    clear_items = 0;
    unused_items = 0;
    counts_written = "";
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: full width display
    set_digit_count(4'd8);
    set_idling(IDLE_NONE);
    send_item(sndw_pkg::CMD_NUMBER, 32'd0, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_NUMBER, 32'd1, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_NUMBER, 32'hFFFF_FFFF, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_NUMBER, 32'h7FFF_FFFF, 3'd0, 8'd0, 1'b0);   // top digits dropped
    send_item(sndw_pkg::CMD_NUMBER, 32'h8000_0000, 3'd0, 8'd0, 1'b0);   // most negative
    send_item(sndw_pkg::CMD_NUMBER, 32'd12345678, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_NUMBER, -32'sd12345678, 3'd0, 8'd0, 1'b0);  // minus has no room
    send_item(sndw_pkg::CMD_NUMBER, -32'sd1234567, 3'd0, 8'd0, 1'b0);   // minus in last slot
    send_item(sndw_pkg::CMD_DIGIT, 32'd0, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_DIGIT, 32'd0, 3'd7, 8'd9, 1'b1);
    send_item(sndw_pkg::CMD_DIGIT, 32'd0, 3'd3, 8'd10, 1'b0);           // above 9 gives blank
    send_item(sndw_pkg::CMD_DIGIT, 32'd0, 3'd5, 8'd255, 1'b1);
    send_item(sndw_pkg::CMD_CLEAR, 32'd0, 3'd0, 8'd0, 1'b0);
    send_item(CMD_UNUSED, '1, '1, '1, 1'b1);

    // Directed: narrow display
    set_digit_count(4'd3);
    send_item(sndw_pkg::CMD_DIGIT, 32'd0, 3'd5, 8'd4, 1'b1);            // position out of range
    send_item(sndw_pkg::CMD_DIGIT, 32'd0, 3'd2, 8'd3, 1'b0);
    send_item(sndw_pkg::CMD_NUMBER, -32'sd123, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_NUMBER, 32'd12345, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_NUMBER, -32'sd12, 3'd0, 8'd0, 1'b0);
    send_item(sndw_pkg::CMD_CLEAR, 32'd0, 3'd0, 8'd0, 1'b0);

    // Random phases over digit counts and idling patterns
    run_phase(4'd1, IDLE_SENDER, 20);
    run_phase(4'd0, IDLE_RECEIVER, 20);
    run_phase(4'd15, IDLE_BOTH, 35);
    run_phase(4'($urandom_range(2, 7)), IDLE_NONE, 40);
    run_phase(4'd8, IDLE_SENDER, 40);
    run_phase(4'($urandom_range(2, 7)), IDLE_RECEIVER, 40);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d show-number, %0d show-digit, %0d clear and %0d unused-code items;",
             number_items, digit_items, clear_items, unused_items);
    $display("checked %0d digit writes with digit counts%s.", writes_checked, counts_written);
    if (fail_count == 0) begin
      $display("signed_number_digit_register_writer_unit_test OK");
    end else begin
      $display("signed_number_digit_register_writer_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sndw_pkg.sv
hdl/sndw_bcd_cell.sv
hdl/sndw_bcd_chain.sv
hdl/signed_number_digit_register_writer_unit.sv
sim/digit_write_checker.sv
sim/signed_number_digit_register_writer_unit_test.sv
